/* rtl/core/wid_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wid_pkg
// Shared widths, stage records and helpers for the wide integer divider.
// ----------------------------------------------------------------------------
package wid_pkg;

	localparam int HALF_WIDTH = 64;
	localparam int DW         = 2 * HALF_WIDTH;
	localparam int AW         = 2 * DW;
	localparam int STEPS      = DW;

	typedef struct packed {
		logic          valid;
		logic [AW-1:0] acc;
		logic [DW-1:0] dvs;
		logic          q_neg;
		logic          r_neg;
	} stage_t;

	typedef struct packed {
		logic          valid;
		logic [DW-1:0] quo;
		logic [DW-1:0] rem;
	} res_t;

	function automatic logic [DW-1:0] neg_w(input logic [DW-1:0] x);
		return ~x + {{(DW-1){1'b0}}, 1'b1};
	endfunction

endpackage

/* rtl/core/wid_prep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wid_prep
// Operand entry stage: take magnitudes in signed mode and record the signs.
// ----------------------------------------------------------------------------
module wid_prep
	import wid_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  req_valid,
	input  logic [HALF_WIDTH-1:0] dividend_high,
	input  logic [HALF_WIDTH-1:0] dividend_low,
	input  logic [HALF_WIDTH-1:0] divisor_high,
	input  logic [HALF_WIDTH-1:0] divisor_low,
	input  logic                  signed_mode,
	output stage_t                stg_s0
);

	logic [DW-1:0] num;
	logic [DW-1:0] dvs;
	logic          n_neg;
	logic          d_neg;
	stage_t        nxt;

	always_comb begin
		num       = {dividend_high, dividend_low};
		dvs       = {divisor_high, divisor_low};
		n_neg     = signed_mode & num[DW-1];
		d_neg     = signed_mode & dvs[DW-1];
		nxt.valid = req_valid;
		nxt.acc   = {{DW{1'b0}}, (n_neg ? neg_w(num) : num)};
		nxt.dvs   = d_neg ? neg_w(dvs) : dvs;
		nxt.q_neg = n_neg ^ d_neg;
		nxt.r_neg = n_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_s0.valid <= 1'b0;
		end else if (en) begin
			stg_s0 <= nxt;
		end
	end

endmodule

/* rtl/core/wid_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wid_step
// One restoring step: shift in a dividend bit, trial subtract, set quotient bit.
// ----------------------------------------------------------------------------
module wid_step
	import wid_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  stage_t stg_in,
	output stage_t stg_out
);

	logic [AW-1:0] sh;
	logic [DW:0]   diff;
	stage_t        nxt;

	always_comb begin
		sh   = {stg_in.acc[AW-2:0], 1'b0};
		diff = {1'b0, sh[AW-1:DW]} - {1'b0, stg_in.dvs};
		nxt  = stg_in;
		if (!diff[DW]) begin
			nxt.acc = {diff[DW-1:0], sh[DW-1:1], 1'b1};
		end else begin
			nxt.acc = sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_out.valid <= 1'b0;
		end else if (en) begin
			stg_out <= nxt;
		end
	end

endmodule

/* rtl/core/wid_post.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wid_post
// Result stage: split quotient and remainder and apply the sign rules.
// ----------------------------------------------------------------------------
module wid_post
	import wid_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  stage_t stg_in,
	output res_t   res_s129
);

	logic [DW-1:0] quo;
	logic [DW-1:0] rem;
	res_t          nxt;

	always_comb begin
		quo       = stg_in.acc[DW-1:0];
		rem       = stg_in.acc[AW-1:DW];
		nxt.valid = stg_in.valid;
		nxt.quo   = stg_in.q_neg ? neg_w(quo) : quo;
		nxt.rem   = stg_in.r_neg ? neg_w(rem) : rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s129.valid <= 1'b0;
		end else if (en) begin
			res_s129 <= nxt;
		end
	end

endmodule

/* rtl/core/wide_integer_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_integer_divider
// Pipeline: entry, 128 steps, sign, output registers from request to result.
// Throughput: one request per cycle while the skid register is empty; one restoring step per pipeline stage.
// A full skid register stalls the whole pipeline until the output drains.
// Reset: arst_n asynchronously clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module wide_integer_divider
	import wid_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [HALF_WIDTH-1:0] dividend_high,
	input  logic [HALF_WIDTH-1:0] dividend_low,
	input  logic [HALF_WIDTH-1:0] divisor_high,
	input  logic [HALF_WIDTH-1:0] divisor_low,
	input  logic                  signed_mode,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [HALF_WIDTH-1:0] quotient_high,
	output logic [HALF_WIDTH-1:0] quotient_low,
	output logic [HALF_WIDTH-1:0] remainder_high,
	output logic [HALF_WIDTH-1:0] remainder_low
);

	logic   en;
	stage_t stg_s [STEPS+1];
	res_t   res_s129;
	res_t   ov_q;
	res_t   sk_q;

	assign en       = !sk_q.valid;
	assign in_ready = en;

	wid_prep u_prep (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.req_valid     (in_valid),
		.dividend_high (dividend_high),
		.dividend_low  (dividend_low),
		.divisor_high  (divisor_high),
		.divisor_low   (divisor_low),
		.signed_mode   (signed_mode),
		.stg_s0        (stg_s[0])
	);

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		wid_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.stg_in  (stg_s[k]),
			.stg_out (stg_s[k+1])
		);
	end

	wid_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.stg_in   (stg_s[STEPS]),
		.res_s129 (res_s129)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q.valid <= 1'b0;
			sk_q.valid <= 1'b0;
		end else if (sk_q.valid) begin
			if (out_ready) begin
				ov_q       <= sk_q;
				sk_q.valid <= 1'b0;
			end
		end else if (res_s129.valid) begin
			if (ov_q.valid && !out_ready) begin
				sk_q <= res_s129;
			end else begin
				ov_q <= res_s129;
			end
		end else if (out_ready) begin
			ov_q.valid <= 1'b0;
		end
	end

	assign out_valid      = ov_q.valid;
	assign quotient_high  = ov_q.quo[DW-1:HALF_WIDTH];
	assign quotient_low   = ov_q.quo[HALF_WIDTH-1:0];
	assign remainder_high = ov_q.rem[DW-1:HALF_WIDTH];
	assign remainder_low  = ov_q.rem[HALF_WIDTH-1:0];

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wide integer divider: a queue-fed driver offers
// signed and unsigned divisions with random gaps, a monitor predicts each
// quotient and remainder with its own restoring loop and checks every result.
// ----------------------------------------------------------------------------
module tb;

	import wid_pkg::*;

	localparam int          RANDOM_ITEMS = 1700;
	localparam int          LATENCY      = 131;
	localparam int          PRESSURE_AT  = 800;
	localparam int          HOLD_CYCLES  = 400;
	localparam longint      TIMEOUT_NS   = 20_000_000;
	localparam logic [DW-1:0] ALL_ONES   = {DW{1'b1}};
	localparam logic [DW-1:0] MOST_NEG   = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] MOST_POS   = {1'b0, {(DW-1){1'b1}}};

	typedef struct {
		logic [DW-1:0] num;
		logic [DW-1:0] den;
		logic          sm;
	} div_req_t;

	typedef struct {
		logic [DW-1:0] quo;
		logic [DW-1:0] rem;
	} div_res_t;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  in_valid       = 1'b0;
	logic                  in_ready;
	logic [HALF_WIDTH-1:0] dividend_high  = '0;
	logic [HALF_WIDTH-1:0] dividend_low   = '0;
	logic [HALF_WIDTH-1:0] divisor_high   = '0;
	logic [HALF_WIDTH-1:0] divisor_low    = '0;
	logic                  signed_mode    = 1'b0;
	logic                  out_valid;
	logic                  out_ready      = 1'b0;
	logic [HALF_WIDTH-1:0] quotient_high;
	logic [HALF_WIDTH-1:0] quotient_low;
	logic [HALF_WIDTH-1:0] remainder_high;
	logic [HALF_WIDTH-1:0] remainder_low;

	div_req_t divisions_to_send[$];
	div_res_t quotients_due[$];

	int  total_requests  = 0;
	int  requests_sent   = 0;
	int  results_seen    = 0;
	int  signed_count    = 0;
	int  zero_div_count  = 0;
	int  in_stall_cycles = 0;
	int  errors          = 0;
	logic req_taken      = 1'b0;
	bit  quiet           = 1'b0;
	int  gap_left        = 0;
	int  stall_left      = 0;
	int  hold_left       = 0;
	bit  held_off        = 1'b0;

	wide_integer_divider i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.dividend_high  (dividend_high),
		.dividend_low   (dividend_low),
		.divisor_high   (divisor_high),
		.divisor_low    (divisor_low),
		.signed_mode    (signed_mode),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.quotient_high  (quotient_high),
		.quotient_low   (quotient_low),
		.remainder_high (remainder_high),
		.remainder_low  (remainder_low)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic div_res_t divide_wide(input logic [DW-1:0] num,
		input logic [DW-1:0] den, input logic sm);
		div_res_t      res;
		logic [DW-1:0] n;
		logic [DW-1:0] d;
		logic [DW-1:0] q;
		logic [DW-1:0] r;
		logic          q_neg;
		logic          r_neg;
		n     = num;
		d     = den;
		q     = '0;
		r     = '0;
		q_neg = 1'b0;
		r_neg = 1'b0;
		if (sm) begin
			q_neg = num[DW-1] ^ den[DW-1];
			r_neg = num[DW-1];
			if (num[DW-1])
				n = ~num + 1'b1;
			if (den[DW-1])
				d = ~den + 1'b1;
		end
		// shift drops the top bit, as the hardware remainder register does
		for (int i = DW - 1; i >= 0; i--) begin
			r = {r[DW-2:0], n[i]};
			if (r >= d) begin
				r    = r - d;
				q[i] = 1'b1;
			end
		end
		res.quo = q_neg ? ~q + 1'b1 : q;
		res.rem = r_neg ? ~r + 1'b1 : r;
		return res;
	endfunction

	function automatic logic [DW-1:0] rand_operand();
		logic [DW-1:0] v;
		v = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 7))
					0: v = '0;
					1: v = 1;
					2: v = 2;
					3: v = ALL_ONES;
					4: v = MOST_NEG;
					5: v = MOST_POS;
					6: v = ALL_ONES - 1'b1;
					default: v = MOST_NEG + 1'b1;
				endcase
			end
			1, 2, 3: v = v >> $urandom_range(0, DW - 1);
			4: v = ~(v >> $urandom_range(1, DW - 1)) + 1'b1;
			default: ;
		endcase
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_division(input logic [DW-1:0] num, input logic [DW-1:0] den,
		input logic sm);
		div_req_t req;
		req.num = num;
		req.den = den;
		req.sm  = sm;
		divisions_to_send.push_back(req);
	endtask

	task automatic check_half(input string what, input logic [HALF_WIDTH-1:0] want,
		input logic [HALF_WIDTH-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
		end
	endtask

	// driver: hold the request until taken, then idle for the chosen gap
	always @(negedge clk) begin : drive_proc
		div_req_t req;
		if (arst_n && !(in_valid && !req_taken)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (divisions_to_send.size() > 0) begin
				req = divisions_to_send.pop_front();
				dividend_high <= req.num[DW-1:HALF_WIDTH];
				dividend_low  <= req.num[HALF_WIDTH-1:0];
				divisor_high  <= req.den[DW-1:HALF_WIDTH];
				divisor_low   <= req.den[HALF_WIDTH-1:0];
				signed_mode   <= req.sm;
				in_valid      <= 1'b1;
				gap_left      <= pick_gap();
				if ($urandom_range(0, 39) == 0)
					quiet <= ~quiet;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off to fill the pipeline
	always @(negedge clk) begin : ready_proc
		int r;
		if (arst_n) begin
			if (!held_off && requests_sent >= PRESSURE_AT) begin
				held_off  = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet) begin
					r = $urandom_range(0, 99);
					if (r < 15)
						stall_left = $urandom_range(1, 3);
					else if (r < 18)
						stall_left = $urandom_range(8, 50);
				end
			end
		end
	end

	always @(posedge clk) begin : check_proc
		div_res_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (quotients_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: quotient %h_%h, remainder %h_%h",
						$time, quotient_high, quotient_low, remainder_high, remainder_low);
				end else begin
					want = quotients_due.pop_front();
					check_half("quotient_high", want.quo[DW-1:HALF_WIDTH], quotient_high);
					check_half("quotient_low", want.quo[HALF_WIDTH-1:0], quotient_low);
					check_half("remainder_high", want.rem[DW-1:HALF_WIDTH], remainder_high);
					check_half("remainder_low", want.rem[HALF_WIDTH-1:0], remainder_low);
					results_seen++;
				end
			end
			if (in_valid && in_ready) begin
				quotients_due.push_back(divide_wide({dividend_high, dividend_low},
					{divisor_high, divisor_low}, signed_mode));
				requests_sent <= requests_sent + 1;
				if (signed_mode)
					signed_count++;
				if ({divisor_high, divisor_low} == '0)
					zero_div_count++;
			end
			if (in_valid && !in_ready)
				in_stall_cycles++;
			req_taken <= in_valid && in_ready;
		end
	end

	initial begin
		// directed corners: zero divisor, wrap, signs, half boundaries
		add_division('0, '0, 1'b0);
		add_division(ALL_ONES, '0, 1'b1);
		add_division(12345, '0, 1'b0);
		add_division(~DW'(12345) + 1'b1, '0, 1'b1);
		add_division(MOST_NEG, ALL_ONES, 1'b1);
		add_division(MOST_NEG, 1, 1'b1);
		add_division(MOST_NEG, MOST_NEG, 1'b1);
		add_division(MOST_POS, ALL_ONES, 1'b1);
		add_division(ALL_ONES, ALL_ONES, 1'b0);
		add_division(ALL_ONES, 1, 1'b0);
		add_division(1, ALL_ONES, 1'b0);
		add_division(ALL_ONES, MOST_NEG, 1'b0);
		add_division(ALL_ONES, MOST_NEG + 1'b1, 1'b0);
		add_division(MOST_POS, MOST_POS, 1'b0);
		add_division(7, ~DW'(2) + 1'b1, 1'b1);
		add_division(~DW'(7) + 1'b1, 2, 1'b1);
		add_division(~DW'(7) + 1'b1, ~DW'(2) + 1'b1, 1'b1);
		add_division(7, 2, 1'b1);
		add_division(ALL_ONES, 2, 1'b1);
		add_division(5, MOST_POS, 1'b1);
		add_division({{(HALF_WIDTH-1){1'b0}}, 1'b1, {HALF_WIDTH{1'b0}}},
			{{HALF_WIDTH{1'b0}}, 1'b1, {(HALF_WIDTH-1){1'b0}}}, 1'b0);
		add_division({{HALF_WIDTH{1'b1}}, {HALF_WIDTH{1'b0}}},
			{{HALF_WIDTH{1'b0}}, {HALF_WIDTH{1'b1}}}, 1'b1);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			add_division(rand_operand(), rand_operand(), 1'($urandom_range(0, 1)));
		total_requests = divisions_to_send.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (requests_sent == total_requests);
		wait (quotients_due.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);

		$display("Ran %0d divisions (%0d signed, %0d by zero), %0d results checked.",
			requests_sent, signed_count, zero_div_count, results_seen);
		$display("Input back-pressure seen on %0d cycles.", in_stall_cycles);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timeout after %0t with %0d results outstanding", $time,
			quotients_due.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
